FILE: src/apumix_pkg.sv
// ----------------------------------------------------------------------------
// apumix_pkg
// Shared widths, mixer curve constants and the sequencer state type of the
// averaging nonlinear APU mixer.
// ----------------------------------------------------------------------------
package apumix_pkg;

	// Channel and field widths.
	localparam int CHANNELS        = 5;
	localparam int SUM_WIDTH       = 24;
	localparam int SQUARE_WIDTH    = 4;
	localparam int DMC_WIDTH       = 7;
	localparam int SAMPLE_WIDTH    = 14;
	localparam int AVG_WIDTH       = 8;
	localparam int COUNT_WIDTH_DEF = 16;

	// Channel slots in the running sums.
	localparam int CH_PULSE_ONE = 0;
	localparam int CH_PULSE_TWO = 1;
	localparam int CH_TRIANGLE  = 2;
	localparam int CH_NOISE     = 3;
	localparam int CH_DMC       = 4;

	// Lookup table depths and the largest legal index of each.
	localparam int PULSE_DEPTH = 31;
	localparam int TND_DEPTH   = 203;
	localparam int PULSE_LAST  = PULSE_DEPTH - 1;
	localparam int TND_LAST    = TND_DEPTH - 1;
	localparam int PULSE_IDX_W = $clog2(PULSE_DEPTH);
	localparam int TND_IDX_W   = $clog2(TND_DEPTH);

	// Mixer curves in exact integer form.
	//   pulse[i] = ceil(9552*16383*i / (812800 + 10000*i)) - 8192
	//   tnd[i]   = floor(16367*16383*i / (2432900 + 10000*i))
	localparam longint unsigned PULSE_NUM_K = 64'd156490416;
	localparam longint unsigned PULSE_DEN_0 = 64'd812800;
	localparam longint unsigned TND_NUM_K   = 64'd268140561;
	localparam longint unsigned TND_DEN_0   = 64'd2432900;
	localparam longint unsigned DEN_STEP    = 64'd10000;
	localparam longint          SAMPLE_BIAS = 64'sd8192;

	// Command codes of an input word.
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_INDEX,
		ST_EMIT
	} apumix_state_t;

endpackage

FILE: src/apumix_if.sv
// ----------------------------------------------------------------------------
// apumix_if
// Valid/ready channels of the mixer: channel levels in, mixed samples out.
// ----------------------------------------------------------------------------
interface apumix_level_if
	import apumix_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    cmd;
	logic [SQUARE_WIDTH-1:0] pulse_one;
	logic [SQUARE_WIDTH-1:0] pulse_two;
	logic [SQUARE_WIDTH-1:0] triangle_level;
	logic [SQUARE_WIDTH-1:0] noise_level;
	logic [DMC_WIDTH-1:0]    dmc_level;

	modport source (output valid, cmd, pulse_one, pulse_two, triangle_level,
		noise_level, dmc_level, input ready);
	modport sink (input valid, cmd, pulse_one, pulse_two, triangle_level,
		noise_level, dmc_level, output ready);
endinterface

interface apumix_sample_if
	import apumix_pkg::*;
();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface

FILE: src/apu_averaging_nonlinear_mixer.sv
// ----------------------------------------------------------------------------
// apu_averaging_nonlinear_mixer
// Averages the five APU channel levels over the ticks between two sample
// requests and mixes the averages through the nonlinear pulse and tnd curves.
// ----------------------------------------------------------------------------
//
//   channel   dir   word                                       accepted when
//   --------  ----  -----------------------------------------  -------------
//   levels    in    cmd, pulse_one/two, triangle, noise, dmc   valid & ready
//   samples   out   sample (14-bit signed)                     valid & ready
//
// A tick word updates the five sums and the tick count at the accepting edge,
// unless the count is already full, and levels.ready stays high. For a sample
// request a single restoring subtractor produces one quotient bit per cycle,
// 24 bits for each of the five channels in turn; then the index state builds
// the table indices and the emit state loads the output register. The emit
// step waits while an earlier sample is still held in the output register.
// Reset clears the sums, the tick count, the sequencer and the output valid.
//
module apu_averaging_nonlinear_mixer
	import apumix_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input logic            clk,
	input logic            arst_n,
	apumix_level_if.sink   levels,
	apumix_sample_if.source samples
);

	localparam int BIT_W = $clog2(SUM_WIDTH);
	localparam int CH_W  = $clog2(CHANNELS);
	localparam logic [BIT_W-1:0]       BIT_LAST  = BIT_W'(SUM_WIDTH - 1);
	localparam logic [CH_W-1:0]        CH_LAST   = CH_W'(CHANNELS - 1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = '1;

	// Constant mixer tables, worked out at elaboration from the exact
	// rational form of the curves.
	logic [SAMPLE_WIDTH-1:0] pulse_rom [PULSE_DEPTH];
	logic [SAMPLE_WIDTH-1:0] tnd_rom   [TND_DEPTH];

	for (genvar i = 0; i < PULSE_DEPTH; i++) begin : g_pulse
		localparam longint unsigned PNUM = PULSE_NUM_K * i;
		localparam longint unsigned PDEN = PULSE_DEN_0 + DEN_STEP * i;
		localparam longint PVAL = longint'((PNUM + PDEN - 64'd1) / PDEN) - SAMPLE_BIAS;
		assign pulse_rom[i] = PVAL[SAMPLE_WIDTH-1:0];
	end

	for (genvar i = 0; i < TND_DEPTH; i++) begin : g_tnd
		localparam longint unsigned TNUM = TND_NUM_K * i;
		localparam longint unsigned TDEN = TND_DEN_0 + DEN_STEP * i;
		localparam longint unsigned TVAL = TNUM / TDEN;
		assign tnd_rom[i] = TVAL[SAMPLE_WIDTH-1:0];
	end

	apumix_state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0] count_q;
	logic [SUM_WIDTH-1:0]   sums_q [CHANNELS];
	logic [AVG_WIDTH-1:0]   avg_q  [CHANNELS];

	// Divider registers: the quotient register also shifts the dividend out.
	logic [SUM_WIDTH-1:0]   quo_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [BIT_W-1:0]       bit_q;
	logic [CH_W-1:0]        ch_q;

	logic [PULSE_IDX_W-1:0]  pulse_idx_q;
	logic [TND_IDX_W-1:0]    tnd_idx_q;
	logic [SAMPLE_WIDTH-1:0] sample_q;
	logic                    out_valid_q;

	logic level_ready;
	logic div_step;
	logic emit_fire;
	logic accept;
	logic tick_fire;
	logic req_fire;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (bit_q == BIT_LAST && ch_q == CH_LAST) begin
					state_d = ST_INDEX;
				end
			end
			ST_INDEX: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		level_ready = 1'b0;
		div_step    = 1'b0;
		emit_fire   = 1'b0;
		unique case (state_q)
			ST_IDLE:   level_ready = 1'b1;
			ST_DIVIDE: div_step = 1'b1;
			ST_INDEX:  ;
			ST_EMIT:   emit_fire = !out_valid_q || samples.ready;
			default:   ;
		endcase
	end

	assign levels.ready = level_ready;
	assign accept       = levels.valid && level_ready;
	assign tick_fire    = accept && (levels.cmd == CMD_TICK);
	assign req_fire     = accept && (levels.cmd == CMD_SAMPLE);

	// Levels of the accepted tick, widened to the sum width.
	logic [SUM_WIDTH-1:0] lv [CHANNELS];
	assign lv[CH_PULSE_ONE] = SUM_WIDTH'(levels.pulse_one);
	assign lv[CH_PULSE_TWO] = SUM_WIDTH'(levels.pulse_two);
	assign lv[CH_TRIANGLE]  = SUM_WIDTH'(levels.triangle_level);
	assign lv[CH_NOISE]     = SUM_WIDTH'(levels.noise_level);
	assign lv[CH_DMC]       = SUM_WIDTH'(levels.dmc_level);

	// Saturating sums; a tick at full count is dropped as a whole.
	logic [SUM_WIDTH-1:0] sum_next [CHANNELS];
	always_comb begin
		for (int k = 0; k < CHANNELS; k++) begin
			logic [SUM_WIDTH:0] t;
			t = {1'b0, sums_q[k]} + {1'b0, lv[k]};
			sum_next[k] = t[SUM_WIDTH] ? SUM_MAX : t[SUM_WIDTH-1:0];
		end
	end

	// One restoring division step: shift in the next dividend bit and
	// subtract the tick count when it fits.
	logic [COUNT_WIDTH:0]   trial;
	logic [COUNT_WIDTH:0]   diff;
	logic                   fits;
	logic [COUNT_WIDTH-1:0] rem_next;
	logic [SUM_WIDTH-1:0]   quot_next;
	logic [AVG_WIDTH-1:0]   avg_next;

	always_comb begin
		trial     = {rem_q, quo_q[SUM_WIDTH-1]};
		diff      = trial - {1'b0, count_q};
		fits      = trial >= {1'b0, count_q};
		rem_next  = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
		quot_next = {quo_q[SUM_WIDTH-2:0], fits};
		// A zero count would give all ones; the average is zero by definition.
		// Averages never exceed a level's range, so eight bits are kept.
		if (count_q == '0) begin
			avg_next = '0;
		end else if (|quot_next[SUM_WIDTH-1:AVG_WIDTH]) begin
			avg_next = '1;
		end else begin
			avg_next = quot_next[AVG_WIDTH-1:0];
		end
	end

	logic [CH_W-1:0] ch_inc;
	assign ch_inc = ch_q + CH_W'(1);

	// Table indices from the averages, clamped to the table ends.
	logic [AVG_WIDTH:0]   pulse_sum;
	logic [AVG_WIDTH+2:0] tnd_sum;
	always_comb begin
		pulse_sum = {1'b0, avg_q[CH_PULSE_ONE]} + {1'b0, avg_q[CH_PULSE_TWO]};
		tnd_sum   = (AVG_WIDTH+3)'(avg_q[CH_TRIANGLE]) * (AVG_WIDTH+3)'(3)
			+ {(AVG_WIDTH+3)'(avg_q[CH_NOISE]) << 1}
			+ (AVG_WIDTH+3)'(avg_q[CH_DMC]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < CHANNELS; k++) begin
				sums_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (tick_fire && count_q != COUNT_MAX) begin
				count_q <= count_q + COUNT_WIDTH'(1);
				for (int k = 0; k < CHANNELS; k++) begin
					sums_q[k] <= sum_next[k];
				end
			end
			if (emit_fire) begin
				count_q     <= '0;
				out_valid_q <= 1'b1;
				for (int k = 0; k < CHANNELS; k++) begin
					sums_q[k] <= '0;
				end
			end else if (samples.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			ch_q  <= '0;
			bit_q <= '0;
			rem_q <= '0;
			quo_q <= sums_q[0];
		end else if (div_step) begin
			if (bit_q == BIT_LAST) begin
				avg_q[ch_q] <= avg_next;
				if (ch_q != CH_LAST) begin
					ch_q  <= ch_inc;
					bit_q <= '0;
					rem_q <= '0;
					quo_q <= sums_q[ch_inc];
				end
			end else begin
				bit_q <= bit_q + BIT_W'(1);
				rem_q <= rem_next;
				quo_q <= quot_next;
			end
		end
		if (state_q == ST_INDEX) begin
			pulse_idx_q <= (pulse_sum > (AVG_WIDTH+1)'(PULSE_LAST))
				? PULSE_IDX_W'(PULSE_LAST) : pulse_sum[PULSE_IDX_W-1:0];
			tnd_idx_q <= (tnd_sum > (AVG_WIDTH+3)'(TND_LAST))
				? TND_IDX_W'(TND_LAST) : tnd_sum[TND_IDX_W-1:0];
		end
		if (emit_fire) begin
			sample_q <= pulse_rom[pulse_idx_q] + tnd_rom[tnd_idx_q];
		end
	end

	assign samples.valid  = out_valid_q;
	assign samples.sample = sample_q;

endmodule

FILE: src/apumix_checker.sv
// ----------------------------------------------------------------------------
// apumix_checker
// Port-level checks of the averaging mixer, bound to its top level.
// ----------------------------------------------------------------------------
module apumix_checker
	import apumix_pkg::*;
(
	input logic                           clk,
	input logic                           arst_n,
	input logic                           lv_valid,
	input logic                           lv_ready,
	input logic                           lv_cmd,
	input logic                           smp_valid,
	input logic                           smp_ready,
	input logic signed [SAMPLE_WIDTH-1:0] smp_sample
);

	// A tick never takes the block out of its idle state.
	a_tick_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		lv_valid && lv_ready && lv_cmd == CMD_TICK |=> lv_ready)
		else $error("levels.ready dropped after a tick word");

	// A sample request starts the divider, which holds off further words.
	a_request_busy: assert property (@(posedge clk) disable iff (!arst_n)
		lv_valid && lv_ready && lv_cmd == CMD_SAMPLE |=> !lv_ready)
		else $error("levels.ready high right after a sample request");

	// A new sample only appears at the end of a busy sequence.
	a_sample_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(smp_valid) |-> $past(!lv_ready))
		else $error("sample word appeared without a preceding request");

	// A stalled sample word holds its value.
	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && !smp_ready |=> smp_valid && $stable(smp_sample))
		else $error("stalled sample word changed or vanished");

endmodule

bind apu_averaging_nonlinear_mixer apumix_checker u_apumix_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.lv_valid   (levels.valid),
	.lv_ready   (levels.ready),
	.lv_cmd     (levels.cmd),
	.smp_valid  (samples.valid),
	.smp_ready  (samples.ready),
	.smp_sample (samples.sample)
);

FILE: test/apumix_sample_checker.sv
// ----------------------------------------------------------------------------
// apumix_sample_checker
// Watches both channels of the mixer, keeps its own copy of the tick count
// and level sums, predicts each mixed sample and compares it on arrival.
// ----------------------------------------------------------------------------
module apumix_sample_checker
	import apumix_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	apumix_level_if     levels,
	apumix_sample_if    samples,
	output int unsigned mismatches,
	output int unsigned awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned SUM_CEILING = (64'd1 << SUM_WIDTH) - 64'd1;

	logic [COUNT_WIDTH-1:0]         tick_total;
	logic [SUM_WIDTH-1:0]           level_total [CHANNELS];
	logic signed [SAMPLE_WIDTH-1:0] pending_samples [$];
	int unsigned                    fault_count = 0;

	// Pulse curve: ceil(9552 * 16383 * i / (812800 + 10000 * i)) - 8192.
	function automatic longint pulse_curve(input longint unsigned idx);
		longint unsigned num;
		longint unsigned den;
		num = 64'd156490416 * idx;
		den = 64'd812800 + 64'd10000 * idx;
		return longint'((num + den - 64'd1) / den) - 64'sd8192;
	endfunction

	// Triangle, noise and DMC curve: floor(16367 * 16383 * i / (2432900 + 10000 * i)).
	function automatic longint tnd_curve(input longint unsigned idx);
		longint unsigned num;
		longint unsigned den;
		num = 64'd268140561 * idx;
		den = 64'd2432900 + 64'd10000 * idx;
		return longint'(num / den);
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] averaged_mix();
		longint unsigned mean [CHANNELS];
		longint unsigned pair_idx;
		longint unsigned tnd_idx;
		longint          mixed;
		for (int k = 0; k < CHANNELS; k++)
			mean[k] = (tick_total == '0) ? 64'd0 : 64'(level_total[k]) / 64'(tick_total);
		pair_idx = mean[CH_PULSE_ONE] + mean[CH_PULSE_TWO];
		if (pair_idx > PULSE_LAST)
			pair_idx = PULSE_LAST;
		tnd_idx = 64'd3 * mean[CH_TRIANGLE] + 64'd2 * mean[CH_NOISE] + mean[CH_DMC];
		if (tnd_idx > TND_LAST)
			tnd_idx = TND_LAST;
		mixed = pulse_curve(pair_idx) + tnd_curve(tnd_idx);
		return mixed[SAMPLE_WIDTH-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [SAMPLE_WIDTH-1:0] wanted;
		longint unsigned                grown;
		longint unsigned                word_level [CHANNELS];
		if (!arst_n) begin
			tick_total = '0;
			foreach (level_total[k])
				level_total[k] = '0;
			pending_samples.delete();
		end else begin
			if (samples.valid && samples.ready) begin
				if (pending_samples.size() == 0) begin
					$error("sample: no sample expected, got %0d", samples.sample);
					fault_count++;
				end else begin
					wanted = pending_samples.pop_front();
					if (samples.sample !== wanted) begin
						$error("sample: expected %0d, got %0d", wanted, samples.sample);
						fault_count++;
					end
				end
			end
			if (levels.valid && levels.ready) begin
				if (levels.cmd == CMD_SAMPLE) begin
					pending_samples.push_back(averaged_mix());
					tick_total = '0;
					foreach (level_total[k])
						level_total[k] = '0;
				end else if (tick_total != '1) begin
					// A tick at a saturated count is dropped whole.
					word_level[CH_PULSE_ONE] = 64'(levels.pulse_one);
					word_level[CH_PULSE_TWO] = 64'(levels.pulse_two);
					word_level[CH_TRIANGLE]  = 64'(levels.triangle_level);
					word_level[CH_NOISE]     = 64'(levels.noise_level);
					word_level[CH_DMC]       = 64'(levels.dmc_level);
					tick_total = tick_total + COUNT_WIDTH'(1);
					foreach (level_total[k]) begin
						grown = 64'(level_total[k]) + word_level[k];
						level_total[k] = (grown > SUM_CEILING) ? '1 : grown[SUM_WIDTH-1:0];
					end
				end
			end
		end
		awaited <= pending_samples.size();
		mismatches <= fault_count;
	end

endmodule

FILE: test/apu_averaging_nonlinear_mixer_test.sv
// ----------------------------------------------------------------------------
// apu_averaging_nonlinear_mixer_test
// Drives tick and sample request words into the averaging mixer with random
// gaps on the level channel and random stalls on the sample channel, and lets
// a side checker predict and compare every mixed sample.
// ----------------------------------------------------------------------------
module apu_averaging_nonlinear_mixer_test
	import apumix_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Number of words in the random part of the run.
	localparam int RANDOM_WORDS = 1850;
	// A sample request runs the whole divider sequence; this covers one in flight.
	localparam int TAIL_CYCLES = 130;
	localparam int DRAIN_LIMIT = 20000;

	localparam logic [SQUARE_WIDTH-1:0] SQ_MAX  = '1;
	localparam logic [DMC_WIDTH-1:0]    DMC_MAX = '1;

	logic        clk;
	logic        arst_n;
	logic        steady;
	int unsigned mismatches;
	int unsigned awaited;
	int unsigned words_sent;

	apumix_level_if  level_ch ();
	apumix_sample_if sample_ch ();

	apu_averaging_nonlinear_mixer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.levels  (level_ch),
		.samples (sample_ch)
	);

	// The checker sits beside the block and only observes the two channels.
	apumix_sample_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.levels     (level_ch),
		.samples    (sample_ch),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle stretches: mostly none or short, now and then a long one.
	function automatic int unsigned gap_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 15);
		else
			return $urandom_range(30, 90);
	endfunction

	// Presents one word and holds it until the block takes it. Valid stays high
	// into the next word unless a gap is drawn, so back-to-back words never see
	// valid dropped and raised in the same step.
	task automatic send_word(input logic cmd, input logic [SQUARE_WIDTH-1:0] pulse_a,
		input logic [SQUARE_WIDTH-1:0] pulse_b, input logic [SQUARE_WIDTH-1:0] triangle,
		input logic [SQUARE_WIDTH-1:0] noise, input logic [DMC_WIDTH-1:0] dmc);
		int unsigned pause;
		level_ch.valid          <= 1'b1;
		level_ch.cmd            <= cmd;
		level_ch.pulse_one      <= pulse_a;
		level_ch.pulse_two      <= pulse_b;
		level_ch.triangle_level <= triangle;
		level_ch.noise_level    <= noise;
		level_ch.dmc_level      <= dmc;
		@(posedge clk);
		while (!level_ch.ready)
			@(posedge clk);
		words_sent++;
		pause = steady ? 0 : gap_length();
		if (pause != 0) begin
			level_ch.valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
	endtask

	task automatic tick(input logic [SQUARE_WIDTH-1:0] pulse_a,
		input logic [SQUARE_WIDTH-1:0] pulse_b, input logic [SQUARE_WIDTH-1:0] triangle,
		input logic [SQUARE_WIDTH-1:0] noise, input logic [DMC_WIDTH-1:0] dmc);
		send_word(CMD_TICK, pulse_a, pulse_b, triangle, noise, dmc);
	endtask

	// The level fields of a sample request carry random junk; the block must
	// ignore them.
	task automatic ask_sample();
		send_word(CMD_SAMPLE, SQUARE_WIDTH'($urandom_range(0, 15)),
			SQUARE_WIDTH'($urandom_range(0, 15)), SQUARE_WIDTH'($urandom_range(0, 15)),
			SQUARE_WIDTH'($urandom_range(0, 15)), DMC_WIDTH'($urandom_range(0, 127)));
	endtask

	// Holds the sender off until every requested sample has come back. The
	// first edge lets the checker's count take in a request accepted just now.
	task automatic wait_for_samples();
		level_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
	endtask

	// Sample channel: ready toggles with random stalls, with occasional long
	// stretches where it never drops.
	initial begin
		sample_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			sample_ch.ready <= 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(100, 400)) @(posedge clk);
			end else begin
				int unsigned hold;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				hold = gap_length();
				if (hold != 0) begin
					sample_ch.ready <= 1'b0;
					repeat (hold) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int unsigned random_start;
		int unsigned burst;
		int unsigned mode;
		int unsigned roll;
		int unsigned spin;
		logic [SQUARE_WIDTH-1:0] base_a;
		logic [SQUARE_WIDTH-1:0] base_b;
		logic [SQUARE_WIDTH-1:0] base_t;
		logic [SQUARE_WIDTH-1:0] base_n;
		logic [DMC_WIDTH-1:0]    base_d;

		words_sent = 0;
		steady     = 1'b0;
		arst_n     = 1'b0;
		level_ch.valid          <= 1'b0;
		level_ch.cmd            <= CMD_TICK;
		level_ch.pulse_one      <= '0;
		level_ch.pulse_two      <= '0;
		level_ch.triangle_level <= '0;
		level_ch.noise_level    <= '0;
		level_ch.dmc_level      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A request with no ticks behind it averages to zero,
		// which gives the bottom of the output range.
		ask_sample();
		tick('0, '0, '0, '0, '0);
		ask_sample();
		// Every channel at full scale hits the top of both curves.
		tick(SQ_MAX, SQ_MAX, SQ_MAX, SQ_MAX, DMC_MAX);
		ask_sample();
		// Pulse pair only, averaged over two ticks.
		tick(SQ_MAX, '0, '0, '0, '0);
		tick('0, SQ_MAX, '0, '0, '0);
		ask_sample();
		// Triangle, noise and DMC only; the averages truncate.
		tick('0, '0, SQ_MAX, SQ_MAX, DMC_MAX);
		tick('0, '0, '0, '0, '0);
		tick('0, '0, 4'd1, 4'd1, 7'd1);
		ask_sample();
		// Small uneven levels where truncation of the division shows.
		tick(4'd1, 4'd2, 4'd3, 4'd4, 7'd5);
		tick(4'd2, 4'd3, 4'd4, 4'd5, 7'd6);
		ask_sample();
		// Back-to-back request: the sums were just cleared.
		ask_sample();
		// Alternating bit patterns in every field.
		tick(4'hA, 4'h5, 4'hA, 4'h5, 7'h55);
		tick(4'h5, 4'hA, 4'h5, 4'hA, 7'h2A);
		ask_sample();
		wait_for_samples();

		// Random part: bursts of ticks closed by a sample request. Some bursts
		// are empty, which makes zero-count and back-to-back requests.
		random_start = words_sent;
		while (words_sent - random_start < RANDOM_WORDS) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				burst = 0;
			else if (roll < 80)
				burst = $urandom_range(1, 16);
			else if (roll < 97)
				burst = $urandom_range(17, 64);
			else
				burst = $urandom_range(65, 300);
			mode   = $urandom_range(0, 3);
			steady = ($urandom_range(0, 4) == 0);
			base_a = SQUARE_WIDTH'($urandom_range(0, 15));
			base_b = SQUARE_WIDTH'($urandom_range(0, 15));
			base_t = SQUARE_WIDTH'($urandom_range(0, 15));
			base_n = SQUARE_WIDTH'($urandom_range(0, 15));
			base_d = DMC_WIDTH'($urandom_range(0, 127));
			repeat (burst) begin
				case (mode)
					1: begin
						// Each level sits at one of its two extremes.
						tick($urandom_range(0, 1) ? SQ_MAX : '0,
							$urandom_range(0, 1) ? SQ_MAX : '0,
							$urandom_range(0, 1) ? SQ_MAX : '0,
							$urandom_range(0, 1) ? SQ_MAX : '0,
							$urandom_range(0, 1) ? DMC_MAX : '0);
					end
					2: begin
						// Constant levels over the burst average exactly.
						tick(base_a, base_b, base_t, base_n, base_d);
					end
					default: begin
						tick(SQUARE_WIDTH'($urandom_range(0, 15)),
							SQUARE_WIDTH'($urandom_range(0, 15)),
							SQUARE_WIDTH'($urandom_range(0, 15)),
							SQUARE_WIDTH'($urandom_range(0, 15)),
							DMC_WIDTH'($urandom_range(0, 127)));
					end
				endcase
			end
			ask_sample();
			if ($urandom_range(0, 24) == 0)
				wait_for_samples();
		end
		steady = 1'b0;

		// Let everything in flight come out, then give a late or extra sample
		// time to show up.
		level_ch.valid <= 1'b0;
		@(posedge clk);
		for (spin = 0; spin < DRAIN_LIMIT && awaited != 0; spin++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited != 0)
			$error("sample: %0d expected samples never arrived", awaited);
		if (mismatches == 0 && awaited == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#40000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
src/apumix_pkg.sv
src/apumix_if.sv
src/apu_averaging_nonlinear_mixer.sv
src/apumix_checker.sv
test/apumix_sample_checker.sv
test/apu_averaging_nonlinear_mixer_test.sv
